// File: rtl/fiwd_pkg.sv
`timescale 1ns / 1ps

package fiwd_pkg;

  // Field widths
  localparam int unsigned FIRST_W   = 7;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned TIMEOUT_W = 7;
  localparam int unsigned SKIP_W    = 6;
  localparam int unsigned RUN_W     = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned BITCNT_W  = 3;
  localparam int unsigned ZCNT_W    = 3;   // leading zero count, 0..7
  localparam int unsigned THR_W     = 9;   // first + 6*step fits in 9 bits

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_THRESHOLD     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_STEP      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TIMEOUT         = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_CYCLES_TO_SKIP = 8'd3;

  // Register reset values
  localparam logic [FIRST_W-1:0]   FIRST_RESET   = 7'd10;
  localparam logic [STEP_W-1:0]    STEP_RESET    = 5'd7;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 7'd65;
  localparam logic [SKIP_W-1:0]    SKIP_RESET    = 6'd13;

  // Number of thresholds checked before falling back to seven zeros
  localparam int unsigned NUM_THR = 7;

  // Stream widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 24;

  typedef struct packed {
    logic [FIRST_W-1:0]   first_threshold;
    logic [STEP_W-1:0]    threshold_step;
    logic [TIMEOUT_W-1:0] run_timeout;
    logic [SKIP_W-1:0]    sync_cycles_to_skip;
  } cfg_t;

endpackage

// File: rtl/flux_interval_write_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata[0] wsig, s_tuser start_req
// m_*       out        m_tvalid / m_tready  m_tdata data_byte, byte_index; m_tuser write_ended
// cfg_*     in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// One item per cycle unless a held result stalls the input; the input register loads at
// the accepting edge, and the result register loads when the core takes a result item.
// The next item is taken while a result waits; only an item that itself makes
// a result stalls behind a result not yet taken.
// Reset (rst, synchronous) loads the register defaults and clears the decoder.
module flux_interval_write_decoder_top #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fiwd_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] wsig, [7:1] zero
  input  logic                              s_tuser,   // [0] start_req
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fiwd_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] data_byte, [17:8] byte_index
  output logic                              m_tuser,   // [0] write_ended
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fiwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fiwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fiwd_pkg::cfg_t                  cfg;
  logic                            in_valid;
  logic                            in_start;
  logic                            in_wsig;
  logic                            take;
  logic [fiwd_pkg::BYTE_W-1:0]     out_byte;
  logic [fiwd_pkg::INDEX_W-1:0]    out_index;

  fiwd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start <= s_tuser;
      in_wsig  <= s_tdata[0];
    end
  end

  fiwd_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item_start (in_start),
    .item_wsig  (in_wsig),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_index  (out_index),
    .out_ended  (m_tuser)
  );

  assign m_tdata = {6'b0, out_index, out_byte};

endmodule

// File: rtl/fiwd_cfg_regs.sv
`timescale 1ns / 1ps

module fiwd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fiwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fiwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fiwd_pkg::cfg_t                    cfg
);

  // Writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_threshold     <= fiwd_pkg::FIRST_RESET;
      cfg.threshold_step      <= fiwd_pkg::STEP_RESET;
      cfg.run_timeout         <= fiwd_pkg::TIMEOUT_RESET;
      cfg.sync_cycles_to_skip <= fiwd_pkg::SKIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fiwd_pkg::CFG_FIRST_THRESHOLD: begin
          cfg.first_threshold <= cfg_data[fiwd_pkg::FIRST_W-1:0];
        end
        fiwd_pkg::CFG_THRESHOLD_STEP: begin
          cfg.threshold_step <= cfg_data[fiwd_pkg::STEP_W-1:0];
        end
        fiwd_pkg::CFG_RUN_TIMEOUT: begin
          cfg.run_timeout <= cfg_data[fiwd_pkg::TIMEOUT_W-1:0];
        end
        fiwd_pkg::CFG_SYNC_CYCLES_TO_SKIP: begin
          cfg.sync_cycles_to_skip <= cfg_data[fiwd_pkg::SKIP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/fiwd_classify.sv
`timescale 1ns / 1ps

// Turns a run length into the number of leading zero bits (0..7)
module fiwd_classify (
  input  logic [fiwd_pkg::RUN_W-1:0]   run_length,
  input  logic [fiwd_pkg::FIRST_W-1:0] first_threshold,
  input  logic [fiwd_pkg::STEP_W-1:0]  threshold_step,
  output logic [fiwd_pkg::ZCNT_W-1:0]  zeros
);

  logic [fiwd_pkg::NUM_THR-1:0] below;

  // Compare against first + j*step, all thresholds in parallel
  always_comb begin
    for (int j = 0; j < fiwd_pkg::NUM_THR; j++) begin
      below[j] = {2'b00, run_length} <
                 (fiwd_pkg::THR_W'(first_threshold) +
                  fiwd_pkg::THR_W'(j) * fiwd_pkg::THR_W'(threshold_step));
    end
  end

  // Lowest threshold that the run stays under
  always_comb begin
    zeros = fiwd_pkg::ZCNT_W'(fiwd_pkg::NUM_THR);
    for (int j = fiwd_pkg::NUM_THR - 1; j >= 0; j--) begin
      if (below[j]) begin
        zeros = fiwd_pkg::ZCNT_W'(j);
      end
    end
  end

endmodule

// File: rtl/fiwd_core.sv
`timescale 1ns / 1ps

module fiwd_core #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fiwd_pkg::cfg_t                cfg,
  // registered input item
  input  logic                          item_valid,
  input  logic                          item_start,
  input  logic                          item_wsig,
  output logic                          take,
  // result register
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fiwd_pkg::BYTE_W-1:0]   out_byte,
  output logic [fiwd_pkg::INDEX_W-1:0]  out_index,
  output logic                          out_ended
);

  localparam int unsigned LOG_W = $clog2(BUFFER_BYTES);
  localparam int unsigned IDX_W =
    (LOG_W > fiwd_pkg::INDEX_W) ? LOG_W : fiwd_pkg::INDEX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SYNC,
    PH_DECODE
  } phase_t;

  phase_t                          phase, phase_next;
  logic [fiwd_pkg::SKIP_W-1:0]     skip_counter, skip_counter_next;
  logic                            last_level, last_level_next;
  logic [fiwd_pkg::RUN_W-1:0]      run_length, run_length_next;
  logic [fiwd_pkg::BYTE_W-1:0]     shift_byte, shift_byte_next;
  logic [fiwd_pkg::BITCNT_W-1:0]   bit_counter, bit_counter_next;
  logic [IDX_W-1:0]                next_index, next_index_next;

  logic                            res_valid;
  logic [fiwd_pkg::BYTE_W-1:0]     res_byte;
  logic                            res_ended;

  logic [fiwd_pkg::ZCNT_W-1:0]     zeros;
  logic [3:0]                      nbits;      // bits pushed this run, 1..8
  logic [3:0]                      room;       // bits left to fill the byte, 1..8
  logic                            crosses;
  logic [fiwd_pkg::BYTE_W-1:0]     done_byte;
  logic [fiwd_pkg::SKIP_W-1:0]     skip_inc;
  logic [fiwd_pkg::RUN_W:0]        run_inc;
  logic [IDX_W-1:0]                index_inc;

  fiwd_classify u_classify (
    .run_length      (run_length),
    .first_threshold (cfg.first_threshold),
    .threshold_step  (cfg.threshold_step),
    .zeros           (zeros)
  );

  // Bit packing: zeros then a one, at most one byte completes per run
  assign nbits     = {1'b0, zeros} + 4'd1;
  assign room      = 4'd8 - {1'b0, bit_counter};
  assign crosses   = (room <= nbits);
  assign done_byte = fiwd_pkg::BYTE_W'(shift_byte << room) | {7'b0, (room == nbits)};

  assign skip_inc  = skip_counter + 6'd1;
  assign run_inc   = {1'b0, run_length} + 8'd1;
  assign index_inc = (next_index == IDX_LAST) ? '0 : next_index + IDX_W'(1);

  // Next state and result for the item at the input register
  always_comb begin
    phase_next        = phase;
    skip_counter_next = skip_counter;
    last_level_next   = last_level;
    run_length_next   = run_length;
    shift_byte_next   = shift_byte;
    bit_counter_next  = bit_counter;
    next_index_next   = next_index;
    res_valid         = 1'b0;
    res_byte          = done_byte;
    res_ended         = 1'b0;
    if (item_valid) begin
      if (item_start) begin
        // new write: clear everything, sample is the first observation
        skip_counter_next = '0;
        last_level_next   = item_wsig;
        shift_byte_next   = '0;
        bit_counter_next  = '0;
        next_index_next   = '0;
        if (cfg.sync_cycles_to_skip == '0) begin
          phase_next      = PH_DECODE;
          run_length_next = 7'd1;
        end else begin
          phase_next      = PH_SYNC;
          run_length_next = '0;
        end
      end else begin
        unique case (phase)
          PH_SYNC: begin
            // one sync cycle ends on each falling edge
            if (last_level && !item_wsig) begin
              skip_counter_next = skip_inc;
              if (skip_inc == cfg.sync_cycles_to_skip) begin
                phase_next      = PH_DECODE;
                run_length_next = 7'd1;
              end
            end
            last_level_next = item_wsig;
          end
          PH_DECODE: begin
            if (item_wsig == last_level) begin
              if (run_inc > {1'b0, cfg.run_timeout}) begin
                // timeout: end result, drop partial byte
                res_valid         = 1'b1;
                res_byte          = '0;
                res_ended         = 1'b1;
                phase_next        = PH_IDLE;
                skip_counter_next = '0;
                last_level_next   = 1'b0;
                run_length_next   = '0;
                shift_byte_next   = '0;
                bit_counter_next  = '0;
                next_index_next   = '0;
              end else begin
                run_length_next = run_inc[fiwd_pkg::RUN_W-1:0];
              end
            end else begin
              // level change: push the run's code bits
              shift_byte_next  = fiwd_pkg::BYTE_W'(shift_byte << nbits) | 8'd1;
              bit_counter_next = fiwd_pkg::BITCNT_W'({1'b0, bit_counter} + nbits);
              last_level_next  = item_wsig;
              run_length_next  = 7'd1;
              if (crosses) begin
                res_valid       = 1'b1;
                next_index_next = index_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item moves on unless its result would land on a held result
  assign take = item_valid && (!res_valid || !out_valid || out_ready);

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      skip_counter <= '0;
      last_level   <= 1'b0;
      run_length   <= '0;
      shift_byte   <= '0;
      bit_counter  <= '0;
      next_index   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        skip_counter <= skip_counter_next;
        last_level   <= last_level_next;
        run_length   <= run_length_next;
        shift_byte   <= shift_byte_next;
        bit_counter  <= bit_counter_next;
        next_index   <= next_index_next;
      end
      out_valid <= (out_valid && !out_ready) || (take && res_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_byte  <= res_byte;
      out_index <= next_index[fiwd_pkg::INDEX_W-1:0];
      out_ended <= res_ended;
    end
  end

  // Results only come out of the decode phase
  a_res_in_decode: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_start && res_valid) |-> (phase == PH_DECODE))
    else $error("result outside decode phase");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (take && out_valid && !out_ready) |-> !res_valid)
    else $error("held result overwritten");

  // End of write returns to idle with a fresh index
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res_ended) |=> (phase == PH_IDLE && next_index == '0))
    else $error("end result did not clear state");

  // Start clears the byte assembly
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (take && item_start) |=> (bit_counter == '0 && shift_byte == '0 && next_index == '0))
    else $error("start did not clear byte state");

  // Each byte result advances the index
  a_index_moves: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && !res_ended) |=> (next_index != $past(next_index)))
    else $error("index did not advance");

endmodule

// File: tb/tb_flux_interval_write_decoder_top.sv
`timescale 1ns / 1ps

module tb_flux_interval_write_decoder_top;

  localparam int unsigned BUFFER_BYTES = 1024;  // byte_index wraps with INDEX_W bits
  localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no item moving on any channel

  typedef enum logic [1:0] {WR_IDLE, WR_SYNC, WR_DECODE} write_phase_t;

  typedef struct packed {
    logic [fiwd_pkg::BYTE_W-1:0]  data_byte;
    logic [fiwd_pkg::INDEX_W-1:0] byte_index;
    logic                         write_ended;
  } decoded_t;

  // Predicts decoded bytes and end-of-write items, and checks the ones the block returns
  class write_decode_model;
    logic [fiwd_pkg::FIRST_W-1:0]   first_thr;
    logic [fiwd_pkg::STEP_W-1:0]    thr_step;
    logic [fiwd_pkg::TIMEOUT_W-1:0] timeout;
    logic [fiwd_pkg::SKIP_W-1:0]    sync_to_skip;

    write_phase_t                   phase;
    logic [fiwd_pkg::SKIP_W-1:0]    sync_seen;
    logic                           last_level;
    logic [fiwd_pkg::RUN_W-1:0]     run_len;
    logic [fiwd_pkg::BYTE_W-1:0]    shift_byte;
    logic [fiwd_pkg::BITCNT_W-1:0]  bit_cnt;
    logic [fiwd_pkg::INDEX_W-1:0]   next_index;

    decoded_t expected_results[$];
    int errors;
    int results_checked;

    function new();
      first_thr       = fiwd_pkg::FIRST_RESET;
      thr_step        = fiwd_pkg::STEP_RESET;
      timeout         = fiwd_pkg::TIMEOUT_RESET;
      sync_to_skip    = fiwd_pkg::SKIP_RESET;
      errors          = 0;
      results_checked = 0;
      clear_write();
    endfunction

    function void clear_write();
      phase      = WR_IDLE;
      sync_seen  = '0;
      last_level = 1'b0;
      run_len    = '0;
      shift_byte = '0;
      bit_cnt    = '0;
      next_index = '0;
    endfunction

    // Number of leading zeros for a run: first j with len < first + j*step, else 7
    function int zero_count(int len);
      int j;
      for (j = 0; j < 7; j++) begin
        if (len < int'(first_thr) + j * int'(thr_step)) return j;
      end
      return 7;
    endfunction

    function void write_reg(logic [fiwd_pkg::CFG_INDEX_W-1:0] idx,
                            logic [fiwd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fiwd_pkg::CFG_FIRST_THRESHOLD:     first_thr    = data[fiwd_pkg::FIRST_W-1:0];
        fiwd_pkg::CFG_THRESHOLD_STEP:      thr_step     = data[fiwd_pkg::STEP_W-1:0];
        fiwd_pkg::CFG_RUN_TIMEOUT:         timeout      = data[fiwd_pkg::TIMEOUT_W-1:0];
        fiwd_pkg::CFG_SYNC_CYCLES_TO_SKIP: sync_to_skip = data[fiwd_pkg::SKIP_W-1:0];
        default: ;  // unused index: ignored
      endcase
    endfunction

    function void note_sample(logic start, logic level);
      int k;
      int i;
      logic got;
      decoded_t r;
      // start request restarts the write in any phase
      if (start) begin
        clear_write();
        last_level = level;
        if (sync_to_skip == 0) begin
          phase   = WR_DECODE;
          run_len = 1;
        end else begin
          phase = WR_SYNC;
        end
        return;
      end
      case (phase)
        WR_SYNC: begin
          // one sync cycle per high-to-low change
          if (last_level && !level) begin
            sync_seen = sync_seen + 1'b1;
            if (sync_seen == sync_to_skip) begin
              phase   = WR_DECODE;
              run_len = 1;
            end
          end
          last_level = level;
        end
        WR_DECODE: begin
          if (level == last_level) begin
            if (int'(run_len) + 1 > int'(timeout)) begin
              r.data_byte   = '0;
              r.byte_index  = next_index;
              r.write_ended = 1'b1;
              expected_results.push_back(r);
              clear_write();
            end else begin
              run_len = run_len + 1'b1;
            end
          end else begin
            // k zeros then a one, MSB first
            k   = zero_count(int'(run_len));
            got = 1'b0;
            r   = '0;
            for (i = 0; i <= k; i++) begin
              shift_byte = {shift_byte[fiwd_pkg::BYTE_W-2:0], (i == k)};
              if (bit_cnt == 3'd7) begin
                got         = 1'b1;
                r.data_byte = shift_byte;
              end
              bit_cnt = bit_cnt + 1'b1;
            end
            last_level = level;
            run_len    = 1;
            if (got) begin
              r.byte_index  = next_index;
              r.write_ended = 1'b0;
              expected_results.push_back(r);
              next_index = next_index + 1'b1;
            end
          end
        end
        default: ;  // idle: level ignored
      endcase
    endfunction

    function void check_result(logic [fiwd_pkg::BYTE_W-1:0] data_byte,
                               logic [fiwd_pkg::INDEX_W-1:0] byte_index,
                               logic write_ended);
      decoded_t e;
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: data_byte %0h byte_index %0d write_ended %0b",
               data_byte, byte_index, write_ended);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (data_byte !== e.data_byte) begin
        $error("data_byte expected %0h actual %0h", e.data_byte, data_byte);
        errors++;
      end
      if (byte_index !== e.byte_index) begin
        $error("byte_index expected %0d actual %0d", e.byte_index, byte_index);
        errors++;
      end
      if (write_ended !== e.write_ended) begin
        $error("write_ended expected %0b actual %0b", e.write_ended, write_ended);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [fiwd_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // [0] wsig, [7:1] zero
  logic                             s_tuser   = 1'b0;  // [0] start_req
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [fiwd_pkg::M_TDATA_W-1:0]   m_tdata;           // [7:0] data_byte, [17:8] byte_index
  logic                             m_tuser;           // [0] write_ended
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [fiwd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fiwd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  write_decode_model decoder_model;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_sent   = 0;
  int sample_limit   = 2147483647;  // no more samples are sent past this count
  int stall_cycles   = 0;

  // settings the stimulus shapes its runs on
  int cur_first;
  int cur_step;
  int cur_timeout;
  int cur_skip;

  flux_interval_write_decoder_top #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Handshake monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) decoder_model.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) decoder_model.note_sample(s_tuser, s_tdata[0]);
      if (m_tvalid && m_tready)
        decoder_model.check_result(m_tdata[7:0], m_tdata[17:8], m_tuser);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // One sample item; returns at the edge it is taken, or at once when the budget is spent
  task automatic send_sample(logic start, logic level);
    if (samples_sent >= sample_limit) return;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(fiwd_pkg::S_TDATA_W-1){1'b0}}, level};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Hold one level for len ticks
  task automatic send_run(logic level, int len);
    repeat (len) send_sample(1'b0, level);
  endtask

  task automatic write_reg(logic [fiwd_pkg::CFG_INDEX_W-1:0] idx,
                           logic [fiwd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Upper data bits beyond a register's width are random and must be dropped
  task automatic load_config(int first, int step, int tmo, int skip);
    write_reg(fiwd_pkg::CFG_INDEX_W'(int'(fiwd_pkg::CFG_SYNC_CYCLES_TO_SKIP) + 1 +
                                     $urandom_range(251)),
              fiwd_pkg::CFG_DATA_W'($urandom));
    write_reg(fiwd_pkg::CFG_FIRST_THRESHOLD, fiwd_pkg::CFG_DATA_W'(first));
    write_reg(fiwd_pkg::CFG_THRESHOLD_STEP,
              fiwd_pkg::CFG_DATA_W'(step | ($urandom_range(3) << fiwd_pkg::STEP_W)));
    write_reg(fiwd_pkg::CFG_RUN_TIMEOUT, fiwd_pkg::CFG_DATA_W'(tmo));
    write_reg(fiwd_pkg::CFG_SYNC_CYCLES_TO_SKIP,
              fiwd_pkg::CFG_DATA_W'(skip | ($urandom_range(1) << fiwd_pkg::SKIP_W)));
    cfg_valid   <= 1'b0;
    cur_first   = first;
    cur_step    = step;
    cur_timeout = tmo;
    cur_skip    = skip;
  endtask

  // Wait for every expected item, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (decoder_model.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Start, sync toggles, decoded runs, mostly ended by a timeout run
  task automatic random_write();
    logic lvl;
    int   changes;
    int   nruns;
    int   maxlen;
    lvl = 1'($urandom_range(1));
    send_sample(1'b1, lvl);
    repeat ($urandom_range(2)) send_sample(1'b0, lvl);
    changes = 2 * cur_skip + 2;
    if ($urandom_range(7) == 0) changes = $urandom_range(changes);  // sync cut short
    repeat (changes) begin
      lvl = ~lvl;
      send_run(lvl, $urandom_range(1, 3));
    end
    maxlen = cur_first + 7 * cur_step + 1;
    if (cur_timeout < maxlen) maxlen = cur_timeout;
    if (maxlen < 1) maxlen = 1;
    nruns = (maxlen > 20) ? $urandom_range(2, 6) : $urandom_range(4, 40);
    repeat (nruns) begin
      lvl = ~lvl;
      send_run(lvl, $urandom_range(1, maxlen));
    end
    if ($urandom_range(3) != 0) begin
      lvl = ~lvl;
      send_run(lvl, cur_timeout + 2);
    end
  endtask

  // Random level noise with sparse start requests
  task automatic noise_items();
    repeat ($urandom_range(5, 20))
      send_sample($urandom_range(9) == 0, 1'($urandom_range(1)));
  endtask

  task automatic run_phase(int first, int step, int tmo, int skip, int budget);
    int phase_start;
    settle();
    load_config(first, step, tmo, skip);
    phase_start  = samples_sent;
    sample_limit = phase_start + budget;
    while (samples_sent - phase_start < budget) begin
      if ($urandom_range(7) == 0) noise_items();
      else random_write();
    end
  endtask

  // Idle levels, one-tick and max-zero runs, timeout, restarts while busy
  task automatic directed_items();
    load_config(2, 1, 8, 0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_run(1'b0, 2);
    send_run(1'b1, 8);
    send_run(1'b0, 9);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
  endtask

  initial begin
    decoder_model = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver stalls a lot
    send_idle_pct  = 24;
    recv_stall_pct = 57;
    directed_items();
    run_phase(2, 1, 12, 2, 124);
    run_phase(1, 1, 127, 1, 200);
    run_phase(127, 31, 40, 63, 320);

    // the other way round
    settle();
    send_idle_pct  = 57;
    recv_stall_pct = 24;
    run_phase(0, 0, 0, 0, 100);
    run_phase(10, 7, 65, 13, 240);

    // full rate both sides
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(3, 0, 20, 3, 120);
    run_phase(4, 3, 30, 5, 120);

    settle();
    repeat (10) @(posedge clk);
    if (decoder_model.errors == 0 && decoder_model.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fiwd_pkg.sv
rtl/fiwd_cfg_regs.sv
rtl/fiwd_classify.sv
rtl/fiwd_core.sv
rtl/flux_interval_write_decoder_top.sv
tb/tb_flux_interval_write_decoder_top.sv
